// ===== rtl/core/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes and the flag bundle that travels down the pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic is_div;
    logic eq;
    logic dz;
    logic ovf;
    logic neg_r;
    logic neg_i;
    logic pov_r;
    logic pov_i;
  } cau_flags_t;

endpackage

// ===== rtl/core/cau_front.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Three stages: operand capture and products, product sums and scaling,
// and setup of the long division that the cell chain carries out.
// ----------------------------------------------------------------------------
module cau_front
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic signed [DATA_WIDTH-1:0] in_a_real,
  input  logic signed [DATA_WIDTH-1:0] in_a_imag,
  input  logic signed [DATA_WIDTH-1:0] in_b_real,
  input  logic signed [DATA_WIDTH-1:0] in_b_imag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cau_flags_t                   out_flags,
  output logic [DATA_WIDTH-1:0]        out_res_r,
  output logic [DATA_WIDTH-1:0]        out_res_i,
  output logic [2*DATA_WIDTH-1:0]      out_den,
  output logic [2*DATA_WIDTH-1:0]      out_rem_r,
  output logic [2*DATA_WIDTH-1:0]      out_rem_i,
  output logic [DATA_WIDTH:0]          out_low_r,
  output logic [DATA_WIDTH:0]          out_low_i
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int NW = PW + FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Stage 1: operand capture.
  logic                         s1_valid_r;
  logic                         s1_ready;
  logic [1:0]                   op1_r;
  logic signed [DATA_WIDTH-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  // Stage 2: products.
  logic          s2_valid_r;
  logic          s2_ready;
  logic [1:0]    op2_r;
  logic          eq2_r;
  logic [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_qq_r;
  logic [DATA_WIDTH-1:0] as_r_r, as_i_r;
  logic          as_ovf_r;

  // Stage 3: sign and magnitude of the numerators.
  logic                  s3_valid_r;
  logic                  s3_ready;
  cau_flags_t            fl3_r;
  logic [DATA_WIDTH-1:0] res3_r_r, res3_i_r;
  logic [PW-1:0]         mag_r_r, mag_i_r, den3_r;

  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_qq;
  logic [DATA_WIDTH:0]   sum_r, sum_i;
  logic [DATA_WIDTH-1:0] as_r_nxt, as_i_nxt;
  logic                  ovf_ar, ovf_ai;

  assign s1_ready = !s1_valid_r || s2_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s3_ready = !s3_valid_r || out_ready;
  assign in_ready = s1_ready;
  assign out_valid = s3_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
    if (s1_ready && in_valid) begin
      op1_r <= in_operation;
      ar1_r <= in_a_real;
      ai1_r <= in_a_imag;
      br1_r <= in_b_real;
      bi1_r <= in_b_imag;
    end
  end

  assign p_rr = ar1_r * br1_r;
  assign p_ii = ai1_r * bi1_r;
  assign p_ri = ar1_r * bi1_r;
  assign p_ir = ai1_r * br1_r;
  assign p_bb = br1_r * br1_r;
  assign p_qq = bi1_r * bi1_r;

  always_comb begin
    if (op1_r == OP_SUB) begin
      sum_r = {ar1_r[DATA_WIDTH-1], ar1_r} - {br1_r[DATA_WIDTH-1], br1_r};
      sum_i = {ai1_r[DATA_WIDTH-1], ai1_r} - {bi1_r[DATA_WIDTH-1], bi1_r};
    end else begin
      sum_r = {ar1_r[DATA_WIDTH-1], ar1_r} + {br1_r[DATA_WIDTH-1], br1_r};
      sum_i = {ai1_r[DATA_WIDTH-1], ai1_r} + {bi1_r[DATA_WIDTH-1], bi1_r};
    end
    ovf_ar = sum_r[DATA_WIDTH] != sum_r[DATA_WIDTH-1];
    ovf_ai = sum_i[DATA_WIDTH] != sum_i[DATA_WIDTH-1];
    as_r_nxt = ovf_ar ? (sum_r[DATA_WIDTH] ? MIN_VAL : MAX_VAL) : sum_r[DATA_WIDTH-1:0];
    as_i_nxt = ovf_ai ? (sum_i[DATA_WIDTH] ? MIN_VAL : MAX_VAL) : sum_i[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_ready && s1_valid_r) begin
      op2_r    <= op1_r;
      eq2_r    <= (ar1_r == br1_r) && (ai1_r == bi1_r);
      p_rr_r   <= p_rr;
      p_ii_r   <= p_ii;
      p_ri_r   <= p_ri;
      p_ir_r   <= p_ir;
      p_bb_r   <= p_bb;
      p_qq_r   <= p_qq;
      as_r_r   <= as_r_nxt;
      as_i_r   <= as_i_nxt;
      as_ovf_r <= ovf_ar || ovf_ai;
    end
  end

  logic [PW:0] e_rr, e_ii, e_ri, e_ir;
  logic [PW:0] mr, mi, nr, ni, dn, sh_r, sh_i, nr_neg, ni_neg;
  logic        mov_r, mov_i;
  logic [DATA_WIDTH-1:0] mul_r, mul_i;
  cau_flags_t  fl3_nxt;

  always_comb begin
    e_rr = {p_rr_r[PW-1], p_rr_r};
    e_ii = {p_ii_r[PW-1], p_ii_r};
    e_ri = {p_ri_r[PW-1], p_ri_r};
    e_ir = {p_ir_r[PW-1], p_ir_r};
    mr = e_rr - e_ii;
    mi = e_ri + e_ir;
    nr = e_rr + e_ii;
    ni = e_ir - e_ri;
    dn = {p_bb_r[PW-1], p_bb_r} + {p_qq_r[PW-1], p_qq_r};
    sh_r = $signed(mr) >>> FRAC_BITS;
    sh_i = $signed(mi) >>> FRAC_BITS;
    mov_r = !((&sh_r[PW:DATA_WIDTH-1]) || !(|sh_r[PW:DATA_WIDTH-1]));
    mov_i = !((&sh_i[PW:DATA_WIDTH-1]) || !(|sh_i[PW:DATA_WIDTH-1]));
    mul_r = mov_r ? (sh_r[PW] ? MIN_VAL : MAX_VAL) : sh_r[DATA_WIDTH-1:0];
    mul_i = mov_i ? (sh_i[PW] ? MIN_VAL : MAX_VAL) : sh_i[DATA_WIDTH-1:0];
    nr_neg = -nr;
    ni_neg = -ni;
    fl3_nxt        = '0;
    fl3_nxt.is_div = op2_r == OP_DIV;
    fl3_nxt.eq     = eq2_r;
    fl3_nxt.dz     = (op2_r == OP_DIV) && (dn == '0);
    fl3_nxt.ovf    = (op2_r == OP_MUL) ? (mov_r || mov_i) : as_ovf_r;
    fl3_nxt.neg_r  = nr[PW];
    fl3_nxt.neg_i  = ni[PW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
    if (s3_ready && s2_valid_r) begin
      fl3_r    <= fl3_nxt;
      res3_r_r <= (op2_r == OP_MUL) ? mul_r : as_r_r;
      res3_i_r <= (op2_r == OP_MUL) ? mul_i : as_i_r;
      mag_r_r  <= nr[PW] ? nr_neg[PW-1:0] : nr[PW-1:0];
      mag_i_r  <= ni[PW] ? ni_neg[PW-1:0] : ni[PW-1:0];
      den3_r   <= dn[PW-1:0];
    end
  end

  logic [NW-1:0] num_r, num_i, top_r, top_i, den_w;

  always_comb begin
    num_r = NW'(mag_r_r) << FRAC_BITS;
    num_i = NW'(mag_i_r) << FRAC_BITS;
    top_r = num_r >> (DATA_WIDTH + 1);
    top_i = num_i >> (DATA_WIDTH + 1);
    den_w = NW'(den3_r);
    out_flags       = fl3_r;
    out_flags.pov_r = top_r >= den_w;
    out_flags.pov_i = top_i >= den_w;
  end

  assign out_res_r = res3_r_r;
  assign out_res_i = res3_i_r;
  assign out_den   = den3_r;
  assign out_rem_r = top_r[PW-1:0];
  assign out_rem_i = top_i[PW-1:0];
  assign out_low_r = num_r[DATA_WIDTH:0];
  assign out_low_i = num_i[DATA_WIDTH:0];

endmodule

// ===== rtl/core/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit division cell
// Produces one quotient bit for the real and the imaginary numerator and
// hands the partial remainders to the next cell.
// ----------------------------------------------------------------------------
module cau_div_cell
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  cau_flags_t              in_flags,
  input  logic [DATA_WIDTH-1:0]   in_res_r,
  input  logic [DATA_WIDTH-1:0]   in_res_i,
  input  logic [2*DATA_WIDTH-1:0] in_den,
  input  logic [2*DATA_WIDTH-1:0] in_rem_r,
  input  logic [2*DATA_WIDTH-1:0] in_rem_i,
  input  logic [DATA_WIDTH:0]     in_low_r,
  input  logic [DATA_WIDTH:0]     in_low_i,
  input  logic [DATA_WIDTH:0]     in_q_r,
  input  logic [DATA_WIDTH:0]     in_q_i,
  output logic                    out_valid,
  input  logic                    out_ready,
  output cau_flags_t              out_flags,
  output logic [DATA_WIDTH-1:0]   out_res_r,
  output logic [DATA_WIDTH-1:0]   out_res_i,
  output logic [2*DATA_WIDTH-1:0] out_den,
  output logic [2*DATA_WIDTH-1:0] out_rem_r,
  output logic [2*DATA_WIDTH-1:0] out_rem_i,
  output logic [DATA_WIDTH:0]     out_low_r,
  output logic [DATA_WIDTH:0]     out_low_i,
  output logic [DATA_WIDTH:0]     out_q_r,
  output logic [DATA_WIDTH:0]     out_q_i
);

  localparam int PW = 2 * DATA_WIDTH;

  logic                  valid_r;
  cau_flags_t            flags_r;
  logic [DATA_WIDTH-1:0] res_r_r, res_i_r;
  logic [PW-1:0]         den_r, rem_r_r, rem_i_r;
  logic [DATA_WIDTH:0]   low_r_r, low_i_r, q_r_r, q_i_r;

  logic [PW:0]         t_r, t_i, d_r, d_i;
  logic                ge_r, ge_i;
  logic [PW-1:0]       rem_r_nxt, rem_i_nxt;
  logic [DATA_WIDTH:0] q_r_nxt, q_i_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    t_r = {in_rem_r, in_low_r[DATA_WIDTH]};
    t_i = {in_rem_i, in_low_i[DATA_WIDTH]};
    d_r = t_r - {1'b0, in_den};
    d_i = t_i - {1'b0, in_den};
    ge_r = t_r >= {1'b0, in_den};
    ge_i = t_i >= {1'b0, in_den};
    rem_r_nxt = ge_r ? d_r[PW-1:0] : t_r[PW-1:0];
    rem_i_nxt = ge_i ? d_i[PW-1:0] : t_i[PW-1:0];
    q_r_nxt = {in_q_r[DATA_WIDTH-1:0], ge_r};
    q_i_nxt = {in_q_i[DATA_WIDTH-1:0], ge_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      flags_r <= in_flags;
      res_r_r <= in_res_r;
      res_i_r <= in_res_i;
      den_r   <= in_den;
      rem_r_r <= rem_r_nxt;
      rem_i_r <= rem_i_nxt;
      low_r_r <= {in_low_r[DATA_WIDTH-1:0], 1'b0};
      low_i_r <= {in_low_i[DATA_WIDTH-1:0], 1'b0};
      q_r_r   <= q_r_nxt;
      q_i_r   <= q_i_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_flags = flags_r;
  assign out_res_r = res_r_r;
  assign out_res_i = res_i_r;
  assign out_den   = den_r;
  assign out_rem_r = rem_r_r;
  assign out_rem_i = rem_i_r;
  assign out_low_r = low_r_r;
  assign out_low_i = low_i_r;
  assign out_q_r   = q_r_r;
  assign out_q_i   = q_i_r;

endmodule

// ===== rtl/core/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply and divide of signed fixed-point complex numbers.
// ----------------------------------------------------------------------------
// Each input transaction carries an operation code and the operands a and b;
// each output transaction carries the saturated complex result together with
// the equal, divide-by-zero and overflow flags. Both channels use valid and
// ready. Every operation runs through the same pipeline: three front stages
// form products, sums and the division setup, then DATA_WIDTH+1 division
// cells each retire one quotient bit, then an output register packs the
// result. A new transaction can be taken in every cycle while the receiver
// accepts output. Each stage moves forward when the stage after it is empty
// or moving, so empty slots close up while the receiver stalls and input is
// taken until the pipeline is full. Reset empties the pipeline; no output
// transaction is pending after it.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic signed [DATA_WIDTH-1:0] in_a_real,
  input  logic signed [DATA_WIDTH-1:0] in_a_imag,
  input  logic signed [DATA_WIDTH-1:0] in_b_real,
  input  logic signed [DATA_WIDTH-1:0] in_b_imag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_result_real,
  output logic signed [DATA_WIDTH-1:0] out_result_imag,
  output logic                         out_operands_equal,
  output logic                         out_divide_by_zero,
  output logic                         out_overflow
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int NC = DATA_WIDTH + 1;
  localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                  c_valid [0:NC];
  logic                  c_ready [0:NC];
  cau_flags_t            c_flags [0:NC];
  logic [DATA_WIDTH-1:0] c_res_r [0:NC];
  logic [DATA_WIDTH-1:0] c_res_i [0:NC];
  logic [PW-1:0]         c_den   [0:NC];
  logic [PW-1:0]         c_rem_r [0:NC];
  logic [PW-1:0]         c_rem_i [0:NC];
  logic [DATA_WIDTH:0]   c_low_r [0:NC];
  logic [DATA_WIDTH:0]   c_low_i [0:NC];
  logic [DATA_WIDTH:0]   c_q_r   [0:NC];
  logic [DATA_WIDTH:0]   c_q_i   [0:NC];

  cau_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_a_real   (in_a_real),
    .in_a_imag   (in_a_imag),
    .in_b_real   (in_b_real),
    .in_b_imag   (in_b_imag),
    .out_valid   (c_valid[0]),
    .out_ready   (c_ready[0]),
    .out_flags   (c_flags[0]),
    .out_res_r   (c_res_r[0]),
    .out_res_i   (c_res_i[0]),
    .out_den     (c_den[0]),
    .out_rem_r   (c_rem_r[0]),
    .out_rem_i   (c_rem_i[0]),
    .out_low_r   (c_low_r[0]),
    .out_low_i   (c_low_i[0])
  );

  assign c_q_r[0] = '0;
  assign c_q_i[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    cau_div_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (c_valid[k]),
      .in_ready (c_ready[k]),
      .in_flags (c_flags[k]),
      .in_res_r (c_res_r[k]),
      .in_res_i (c_res_i[k]),
      .in_den   (c_den[k]),
      .in_rem_r (c_rem_r[k]),
      .in_rem_i (c_rem_i[k]),
      .in_low_r (c_low_r[k]),
      .in_low_i (c_low_i[k]),
      .in_q_r   (c_q_r[k]),
      .in_q_i   (c_q_i[k]),
      .out_valid(c_valid[k+1]),
      .out_ready(c_ready[k+1]),
      .out_flags(c_flags[k+1]),
      .out_res_r(c_res_r[k+1]),
      .out_res_i(c_res_i[k+1]),
      .out_den  (c_den[k+1]),
      .out_rem_r(c_rem_r[k+1]),
      .out_rem_i(c_rem_i[k+1]),
      .out_low_r(c_low_r[k+1]),
      .out_low_i(c_low_i[k+1]),
      .out_q_r  (c_q_r[k+1]),
      .out_q_i  (c_q_i[k+1])
    );
  end

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] res_real_r, res_imag_r;
  logic                  eq_r, dz_r, ovf_r;

  logic                  last_ready;
  cau_flags_t            fl;
  logic [DATA_WIDTH:0]   qr, qi;
  logic [DATA_WIDTH-1:0] div_r, div_i, res_real_nxt, res_imag_nxt;
  logic                  dov_r, dov_i, ovf_nxt;

  assign last_ready   = !out_valid_r || out_ready;
  assign c_ready[NC]  = last_ready;

  always_comb begin
    fl = c_flags[NC];
    qr = c_q_r[NC];
    qi = c_q_i[NC];
    if (fl.pov_r) begin
      dov_r = 1'b1;
      div_r = fl.neg_r ? MIN_VAL : MAX_VAL;
    end else if (!fl.neg_r) begin
      dov_r = qr[DATA_WIDTH] || qr[DATA_WIDTH-1];
      div_r = dov_r ? MAX_VAL : qr[DATA_WIDTH-1:0];
    end else begin
      dov_r = qr[DATA_WIDTH] || (qr[DATA_WIDTH-1] && (|qr[DATA_WIDTH-2:0]));
      div_r = dov_r ? MIN_VAL : -qr[DATA_WIDTH-1:0];
    end
    if (fl.pov_i) begin
      dov_i = 1'b1;
      div_i = fl.neg_i ? MIN_VAL : MAX_VAL;
    end else if (!fl.neg_i) begin
      dov_i = qi[DATA_WIDTH] || qi[DATA_WIDTH-1];
      div_i = dov_i ? MAX_VAL : qi[DATA_WIDTH-1:0];
    end else begin
      dov_i = qi[DATA_WIDTH] || (qi[DATA_WIDTH-1] && (|qi[DATA_WIDTH-2:0]));
      div_i = dov_i ? MIN_VAL : -qi[DATA_WIDTH-1:0];
    end
    if (!fl.is_div) begin
      res_real_nxt = c_res_r[NC];
      res_imag_nxt = c_res_i[NC];
      ovf_nxt      = fl.ovf;
    end else if (fl.dz) begin
      res_real_nxt = '0;
      res_imag_nxt = '0;
      ovf_nxt      = 1'b0;
    end else begin
      res_real_nxt = div_r;
      res_imag_nxt = div_i;
      ovf_nxt      = dov_r || dov_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_ready) begin
      out_valid_r <= c_valid[NC];
    end
    if (last_ready && c_valid[NC]) begin
      res_real_r <= res_real_nxt;
      res_imag_r <= res_imag_nxt;
      eq_r       <= fl.eq;
      dz_r       <= fl.dz;
      ovf_r      <= ovf_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_real    = res_real_r;
  assign out_result_imag    = res_imag_r;
  assign out_operands_equal = eq_r;
  assign out_divide_by_zero = dz_r;
  assign out_overflow       = ovf_r;

  a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |->
      out_result_real == '0 && out_result_imag == '0 && !out_overflow)
    else $error("divide by zero transaction with nonzero result or overflow");

  a_ovf_sat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      out_result_real == MAX_VAL || out_result_real == MIN_VAL ||
      out_result_imag == MAX_VAL || out_result_imag == MIN_VAL)
    else $error("overflow flagged without a saturated result part");

  a_ready_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input blocked while output register is empty");

endmodule
